// ===== hdl/bfc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared codes and result type of the brainfuck core: program symbols,
// step status codes and the packed result word.
// ----------------------------------------------------------------------------
`default_nettype none

package bfc_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [2:0] {
    SYM_RIGHT = 3'd0,
    SYM_LEFT  = 3'd1,
    SYM_INC   = 3'd2,
    SYM_DEC   = 3'd3,
    SYM_OUT   = 3'd4,
    SYM_IN    = 3'd5,
    SYM_OPEN  = 3'd6,
    SYM_CLOSE = 3'd7
  } sym_t;

  typedef enum logic [2:0] {
    ST_RUNNING        = 3'd0,
    ST_HALTED         = 3'd1,
    ST_UNMATCHED_OPEN = 3'd2,
    ST_STRAY_CLOSE    = 3'd3,
    ST_STACK_OVERFLOW = 3'd4,
    ST_EMPTY          = 3'd5,
    ST_STORE_FULL     = 3'd6
  } status_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       input_used;
    status_t    status;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/bfc_in_if.sv =====
// ----------------------------------------------------------------------------
// bfc_in_if
// Input channel: load or step transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfc_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [2:0] symbol;
  logic [7:0] input_byte;

  modport source (output valid, output opcode, output symbol, output input_byte,
                  input ready);
  modport sink   (input valid, input opcode, input symbol, input input_byte,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/bfc_out_if.sv =====
// ----------------------------------------------------------------------------
// bfc_out_if
// Result channel: one result transaction per accepted input transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfc_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       input_used;
  logic [2:0] status;

  modport source (output valid, output out_valid, output out_byte,
                  output input_used, output status, input ready);
  modport sink   (input valid, input out_valid, input out_byte,
                  input input_used, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/brainfuck_core_unit.sv =====
// ----------------------------------------------------------------------------
// brainfuck_core_unit
// A load, or a step that executes nothing (stopped, empty, halting), is
// finished in S_IDLE; a step that runs an instruction is finished in
// S_EXEC, or for an opening bracket in S_SCAN after a match scan that
// reads the program RAM one address per cycle. Reset clears control
// state, then sweeps every tape RAM address to zero while the input
// channel is held not ready.
// ----------------------------------------------------------------------------
`default_nettype none

module brainfuck_core_unit
  import bfc_pkg::*;
#(
  parameter int TAPE_DEPTH       = 65536,
  parameter int PROGRAM_DEPTH    = 4096,
  parameter int LOOP_STACK_DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bfc_in_if.sink     in_ch,
  bfc_out_if.source  out_ch
);

  // Tape pointer, program address, program counter/length, stack widths
  localparam int TPW = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
  localparam int PAW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int PCW = $clog2(PROGRAM_DEPTH + 1);
  localparam int SAW = (LOOP_STACK_DEPTH > 1) ? $clog2(LOOP_STACK_DEPTH) : 1;
  localparam int SDW = $clog2(LOOP_STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR,   // sweep tape to zero after reset
    S_IDLE,    // accept a transaction; issue reads of pc, tape cell, stack top
    S_EXEC,    // execute the fetched instruction
    S_SCAN,    // walk forward for the close matching an open bracket
    S_WAIT     // hold a finished result until the output register frees
  } state_t;

  state_t           state_r, state_nxt;
  logic [PCW-1:0]   len_r, len_nxt;
  logic [PCW-1:0]   pc_r, pc_nxt;
  logic [TPW-1:0]   tp_r, tp_nxt;
  logic [SDW-1:0]   depth_r, depth_nxt;
  status_t          run_r, run_nxt;
  logic [TPW-1:0]   clr_r, clr_nxt;
  logic [PCW-1:0]   sa_r, sa_nxt;      // scan address whose symbol is arriving
  logic [PCW-1:0]   lvl_r, lvl_nxt;    // bracket nesting level during scan
  logic [7:0]       ibyte_r, ibyte_nxt;
  logic             ovld_r, ovld_nxt;
  res_t             ores_r, ores_nxt;
  res_t             pend_r, pend_nxt;

  // Memory ports
  logic             prog_we;
  logic [PAW-1:0]   prog_waddr, prog_raddr;
  logic [2:0]       prog_wdata, prog_rdata;
  logic             tape_we;
  logic [TPW-1:0]   tape_waddr, tape_raddr;
  logic [7:0]       tape_wdata, tape_rdata;
  logic             stk_we;
  logic [SAW-1:0]   stk_waddr, stk_raddr;
  logic [PAW-1:0]   stk_wdata, stk_rdata;

  logic             slot_free;
  logic             res_done;
  res_t             res;
  sym_t             sym;
  logic [PCW-1:0]   pc_inc;
  logic [SDW-1:0]   depth_dec;

  bfc_ram #(.WIDTH(3), .DEPTH(PROGRAM_DEPTH)) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (prog_wdata),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  bfc_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape_ram (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (tape_raddr),
    .rdata (tape_rdata)
  );

  bfc_ram #(.WIDTH(PAW), .DEPTH(LOOP_STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = ovld_r;
  assign out_ch.out_valid  = ores_r.out_valid;
  assign out_ch.out_byte   = ores_r.out_byte;
  assign out_ch.input_used = ores_r.input_used;
  assign out_ch.status     = ores_r.status;

  // The output register can take a new result when empty or being drained
  assign slot_free = !ovld_r || out_ch.ready;
  assign sym       = sym_t'(prog_rdata);
  assign pc_inc    = pc_r + PCW'(1);
  assign depth_dec = depth_r - SDW'(1);

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    pc_nxt    = pc_r;
    tp_nxt    = tp_r;
    depth_nxt = depth_r;
    run_nxt   = run_r;
    clr_nxt   = clr_r;
    sa_nxt    = sa_r;
    lvl_nxt   = lvl_r;
    ibyte_nxt = ibyte_r;
    ovld_nxt  = ovld_r;
    ores_nxt  = ores_r;
    pend_nxt  = pend_r;

    // Reads default to the current pc, cell and stack top so that their
    // data is ready in the cycle after a step is accepted
    prog_we    = 1'b0;
    prog_waddr = len_r[PAW-1:0];
    prog_wdata = in_ch.symbol;
    prog_raddr = pc_r[PAW-1:0];
    tape_we    = 1'b0;
    tape_waddr = tp_r;
    tape_wdata = 8'd0;
    tape_raddr = tp_r;
    stk_we     = 1'b0;
    stk_waddr  = depth_r[SAW-1:0];
    stk_wdata  = pc_r[PAW-1:0];
    stk_raddr  = depth_dec[SAW-1:0];

    res_done       = 1'b0;
    res.out_valid  = 1'b0;
    res.out_byte   = 8'd0;
    res.input_used = 1'b0;
    res.status     = ST_RUNNING;

    // Drop the held result once the sink takes it
    if (ovld_r && out_ch.ready) begin
      ovld_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_r;
        clr_nxt    = clr_r + TPW'(1);
        if (clr_r == TPW'(TAPE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          ibyte_nxt = in_ch.input_byte;
          if (in_ch.opcode == OP_LOAD) begin
            // Append the symbol, or drop it when the store is full
            if (len_r >= PCW'(PROGRAM_DEPTH)) begin
              res.status = ST_STORE_FULL;
            end else begin
              prog_we = 1'b1;
              len_nxt = len_r + PCW'(1);
            end
            res_done = 1'b1;
          end else begin
            priority if (run_r != ST_RUNNING) begin
              res.status = run_r;
              res_done   = 1'b1;
            end else if (len_r == '0) begin
              res.status = ST_EMPTY;
              res_done   = 1'b1;
            end else if (pc_r >= len_r) begin
              run_nxt    = ST_HALTED;
              res.status = ST_HALTED;
              res_done   = 1'b1;
            end else begin
              state_nxt = S_EXEC;
            end
          end
        end
      end

      S_EXEC: begin
        res_done = 1'b1;
        pc_nxt   = pc_inc;
        unique case (sym)
          SYM_RIGHT: begin
            tp_nxt = (tp_r == TPW'(TAPE_DEPTH - 1)) ? '0 : tp_r + TPW'(1);
          end
          SYM_LEFT: begin
            tp_nxt = (tp_r == '0) ? TPW'(TAPE_DEPTH - 1) : tp_r - TPW'(1);
          end
          SYM_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 8'd1;
          end
          SYM_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - 8'd1;
          end
          SYM_OUT: begin
            res.out_valid = 1'b1;
            res.out_byte  = tape_rdata;
          end
          SYM_IN: begin
            tape_we        = 1'b1;
            tape_wdata     = ibyte_r;
            res.input_used = 1'b1;
          end
          SYM_OPEN: begin
            // Start the match scan at the symbol after the bracket
            res_done   = 1'b0;
            pc_nxt     = pc_r;
            prog_raddr = pc_inc[PAW-1:0];
            sa_nxt     = pc_inc;
            lvl_nxt    = PCW'(1);
            state_nxt  = S_SCAN;
          end
          SYM_CLOSE: begin
            priority if (depth_r == '0) begin
              run_nxt    = ST_STRAY_CLOSE;
              res.status = ST_STRAY_CLOSE;
              pc_nxt     = pc_r;
            end else if (tape_rdata != 8'd0) begin
              pc_nxt = PCW'(stk_rdata) + PCW'(1);
            end else begin
              depth_nxt = depth_dec;
            end
          end
        endcase
      end

      S_SCAN: begin
        priority if (sa_r >= len_r) begin
          // Ran off the loaded program without a match
          run_nxt    = ST_UNMATCHED_OPEN;
          res.status = ST_UNMATCHED_OPEN;
          res_done   = 1'b1;
        end else if (sym == SYM_CLOSE && lvl_r == PCW'(1)) begin
          res_done = 1'b1;
          priority if (tape_rdata == 8'd0) begin
            pc_nxt = sa_r + PCW'(1);
          end else if (depth_r >= SDW'(LOOP_STACK_DEPTH)) begin
            run_nxt    = ST_STACK_OVERFLOW;
            res.status = ST_STACK_OVERFLOW;
          end else begin
            stk_we    = 1'b1;
            depth_nxt = depth_r + SDW'(1);
            pc_nxt    = pc_inc;
          end
        end else begin
          // Track nesting and advance to the next symbol
          if (sym == SYM_OPEN) begin
            lvl_nxt = lvl_r + PCW'(1);
          end else if (sym == SYM_CLOSE) begin
            lvl_nxt = lvl_r - PCW'(1);
          end
          sa_nxt     = sa_r + PCW'(1);
          prog_raddr = sa_nxt[PAW-1:0];
        end
      end

      S_WAIT: begin
        if (slot_free) begin
          ovld_nxt  = 1'b1;
          ores_nxt  = pend_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Hand a finished result to the output register, or park it
    if (res_done) begin
      if (slot_free) begin
        ovld_nxt  = 1'b1;
        ores_nxt  = res;
        state_nxt = S_IDLE;
      end else begin
        pend_nxt  = res;
        state_nxt = S_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      len_r   <= '0;
      pc_r    <= '0;
      tp_r    <= '0;
      depth_r <= '0;
      run_r   <= ST_RUNNING;
      clr_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      pc_r    <= pc_nxt;
      tp_r    <= tp_nxt;
      depth_r <= depth_nxt;
      run_r   <= run_nxt;
      clr_r   <= clr_nxt;
      ovld_r  <= ovld_nxt;
    end
    sa_r    <= sa_nxt;
    lvl_r   <= lvl_nxt;
    ibyte_r <= ibyte_nxt;
    ores_r  <= ores_nxt;
    pend_r  <= pend_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/bfc_ram.sv =====
// ----------------------------------------------------------------------------
// bfc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for brainfuck_core_unit. A stimulus block plans the
// whole command stream at time zero. It steers the random program so that
// execution keeps running into freshly loaded code, and it ends the run in
// one sticky stop chosen at random. A clocked driver and a clocked monitor
// apply random idle and stall cycles. The monitor predicts each result when
// the input transaction is accepted and compares it with the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bfc_pkg::*;

  localparam int TAPE_DEPTH       = 65536;
  localparam int PROGRAM_DEPTH    = 4096;
  localparam int LOOP_STACK_DEPTH = 64;

  // Interpreter state is kept twice: one copy follows the planned stream
  // while it is built, the other follows accepted transactions for checking.
  localparam int CTX_PLAN  = 0;
  localparam int CTX_CHECK = 1;

  // Stop random program growth at this many queued commands.
  localparam int RANDOM_ITEMS = 560;

  typedef struct packed {
    logic       opcode;
    sym_t       symbol;
    logic [7:0] input_byte;
  } cmd_t;

  typedef enum {END_HALT, END_UNMATCHED, END_STRAY, END_OVERFLOW} ending_t;

  logic clk = 1'b0;
  logic rst_n;

  bfc_in_if  in_ch ();
  bfc_out_if out_ch ();

  brainfuck_core_unit #(
    .TAPE_DEPTH       (TAPE_DEPTH),
    .PROGRAM_DEPTH    (PROGRAM_DEPTH),
    .LOOP_STACK_DEPTH (LOOP_STACK_DEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // --------------------------------------------------------------------------
  // Interpreter state, one set per context
  // --------------------------------------------------------------------------
  bit   [7:0]  tape_mem [2][TAPE_DEPTH];
  sym_t        prog_mem [2][PROGRAM_DEPTH];
  logic [11:0] loop_mem [2][LOOP_STACK_DEPTH];
  int unsigned prog_len [2];
  int unsigned prog_ctr [2];
  int unsigned tape_ptr [2];
  int unsigned loop_lvl [2];
  status_t     run_st   [2];

  cmd_t cmd_backlog[$];      // commands not yet handed to the driver
  res_t pending_results[$];  // predicted results not yet seen at the output

  int unsigned fail_count = 0;

  // Apply one command to the interpreter state of context ctx and return
  // the result that it yields.
  function automatic res_t exec_bf_item(input int ctx, input logic opcode,
                                        input sym_t symbol, input logic [7:0] in_byte);
    res_t        r;
    int unsigned here;
    int unsigned next_pc;
    int unsigned nest;
    int unsigned a;
    int unsigned close_at;
    bit          found;
    r        = '0;
    r.status = ST_RUNNING;
    if (opcode == OP_LOAD) begin
      if (prog_len[ctx] >= PROGRAM_DEPTH) begin
        r.status = ST_STORE_FULL;
      end else begin
        prog_mem[ctx][prog_len[ctx]] = symbol;
        prog_len[ctx]++;
      end
    end else if (run_st[ctx] != ST_RUNNING) begin
      r.status = run_st[ctx];
    end else if (prog_len[ctx] == 0) begin
      r.status = ST_EMPTY;
    end else if (prog_ctr[ctx] >= prog_len[ctx]) begin
      run_st[ctx] = ST_HALTED;
      r.status    = ST_HALTED;
    end else begin
      here    = prog_ctr[ctx];
      next_pc = here + 1;
      case (prog_mem[ctx][here])
        SYM_RIGHT: tape_ptr[ctx] = (tape_ptr[ctx] + 1) % TAPE_DEPTH;
        SYM_LEFT:  tape_ptr[ctx] = (tape_ptr[ctx] == 0) ? TAPE_DEPTH - 1 : tape_ptr[ctx] - 1;
        SYM_INC:   tape_mem[ctx][tape_ptr[ctx]] = tape_mem[ctx][tape_ptr[ctx]] + 8'd1;
        SYM_DEC:   tape_mem[ctx][tape_ptr[ctx]] = tape_mem[ctx][tape_ptr[ctx]] - 8'd1;
        SYM_OUT: begin
          r.out_valid = 1'b1;
          r.out_byte  = tape_mem[ctx][tape_ptr[ctx]];
        end
        SYM_IN: begin
          r.input_used = 1'b1;
          tape_mem[ctx][tape_ptr[ctx]] = in_byte;
        end
        SYM_OPEN: begin
          // Walk forward for the matching close, whatever the cell holds.
          found    = 1'b0;
          nest     = 1;
          close_at = 0;
          for (a = here + 1; a < prog_len[ctx] && !found; a++) begin
            if (prog_mem[ctx][a] == SYM_OPEN) begin
              nest++;
            end else if (prog_mem[ctx][a] == SYM_CLOSE) begin
              nest--;
              if (nest == 0) begin
                found    = 1'b1;
                close_at = a;
              end
            end
          end
          if (!found) begin
            run_st[ctx] = ST_UNMATCHED_OPEN;
            next_pc     = here;
          end else if (tape_mem[ctx][tape_ptr[ctx]] == 8'd0) begin
            next_pc = close_at + 1;
          end else if (loop_lvl[ctx] >= LOOP_STACK_DEPTH) begin
            run_st[ctx] = ST_STACK_OVERFLOW;
            next_pc     = here;
          end else begin
            loop_mem[ctx][loop_lvl[ctx]] = here[11:0];
            loop_lvl[ctx]++;
          end
        end
        default: begin
          // closing bracket
          if (loop_lvl[ctx] == 0) begin
            run_st[ctx] = ST_STRAY_CLOSE;
            next_pc     = here;
          end else if (tape_mem[ctx][tape_ptr[ctx]] != 8'd0) begin
            next_pc = loop_mem[ctx][loop_lvl[ctx] - 1] + 1;
          end else begin
            loop_lvl[ctx]--;
          end
        end
      endcase
      prog_ctr[ctx] = next_pc;
      r.status      = run_st[ctx];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus planning
  // --------------------------------------------------------------------------

  // Queue one command and advance the planning copy past it.
  task automatic queue_cmd(input logic opcode, input sym_t symbol, input logic [7:0] in_byte);
    cmd_t c;
    c.opcode     = opcode;
    c.symbol     = symbol;
    c.input_byte = in_byte;
    void'(exec_bf_item(CTX_PLAN, opcode, symbol, in_byte));
    cmd_backlog.push_back(c);
  endtask

  // A comma right in front of an opening bracket sets the loop count, so
  // keep it small there; anywhere else any byte goes.
  function automatic logic [7:0] pick_input();
    int unsigned at = prog_ctr[CTX_PLAN];
    if (at + 1 < prog_len[CTX_PLAN] && prog_mem[CTX_PLAN][at] == SYM_IN &&
        prog_mem[CTX_PLAN][at + 1] == SYM_OPEN) begin
      return 8'($urandom_range(0, 3));
    end
    return 8'($urandom);
  endfunction

  // Non-bracket symbol; pointer moves only when allowed.
  function automatic sym_t plain_sym(input bit with_moves);
    sym_t pool [6] = '{SYM_INC, SYM_DEC, SYM_OUT, SYM_IN, SYM_RIGHT, SYM_LEFT};
    return pool[$urandom_range(0, with_moves ? 5 : 3)];
  endfunction

  task automatic load_sym(input sym_t s);
    queue_cmd(OP_LOAD, s, 8'($urandom));
  endtask

  task automatic step_once(input logic [7:0] in_byte);
    queue_cmd(OP_STEP, sym_t'($urandom_range(0, 7)), in_byte);
  endtask

  // Load a loop that always terminates: a comma sets the counting cell,
  // the body decrements it exactly once, and everything else in the body
  // outputs that cell or runs one cell to the right with the pointer brought back.
  task automatic load_loop(input int unsigned lvl);
    load_sym(SYM_IN);
    load_sym(SYM_OPEN);
    load_sym(SYM_DEC);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 2) == 0) begin
        load_sym(SYM_OUT);
      end else begin
        load_sym(SYM_RIGHT);
        if (lvl < 2 && $urandom_range(0, 1) == 0) begin
          load_loop(lvl + 1);
        end else begin
          repeat ($urandom_range(1, 2)) load_sym(plain_sym(1'b0));
        end
        load_sym(SYM_LEFT);
      end
    end
    load_sym(SYM_CLOSE);
  endtask

  initial begin
    sym_t        first_prog [9]  = '{SYM_LEFT, SYM_DEC, SYM_OUT, SYM_RIGHT, SYM_IN,
                                     SYM_OPEN, SYM_DEC, SYM_CLOSE, SYM_INC};
    sym_t        second_prog [4] = '{SYM_IN, SYM_OPEN, SYM_DEC, SYM_CLOSE};
    int unsigned remaining;
    int unsigned tail_at;
    int unsigned guard;
    ending_t     ending;

    for (int k = 0; k < 2; k++) run_st[k] = ST_RUNNING;

    // Directed opening: empty program, pointer wrap both ways, cell wrap
    // below zero, output of 255, comma of zero, open bracket skipped on a
    // zero cell, then a loop that jumps back once and pops on exit.
    step_once(8'($urandom));
    foreach (first_prog[k]) load_sym(first_prog[k]);
    repeat (4) step_once(8'($urandom));
    step_once(8'h00);
    repeat (2) step_once(8'($urandom));
    foreach (second_prog[k]) load_sym(second_prog[k]);
    step_once(8'h02);
    repeat (5) step_once(8'($urandom));

    // Random part: grow the program in well-formed fragments and keep
    // stepping into them without ever running off the end.
    while (cmd_backlog.size() < RANDOM_ITEMS) begin
      remaining = prog_len[CTX_PLAN] - prog_ctr[CTX_PLAN];
      if (remaining == 0 || (remaining < 4 && $urandom_range(0, 1) == 0) ||
          $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          load_loop(0);
        end else begin
          repeat ($urandom_range(1, 5)) load_sym(plain_sym(1'b1));
        end
      end else begin
        step_once(pick_input());
      end
    end

    // Finish the program in one sticky stop, chosen per seed.
    ending  = ending_t'($urandom_range(0, 3));
    tail_at = prog_len[CTX_PLAN];
    case (ending)
      END_UNMATCHED: begin
        load_sym(SYM_IN);
        load_sym(SYM_OPEN);
      end
      END_STRAY: load_sym(SYM_CLOSE);
      END_OVERFLOW: begin
        load_sym(SYM_IN);
        repeat (LOOP_STACK_DEPTH + 1) load_sym(SYM_OPEN);
        repeat (LOOP_STACK_DEPTH + 1) load_sym(SYM_CLOSE);
      end
      default: ;
    endcase
    guard = 0;
    while (run_st[CTX_PLAN] == ST_RUNNING && guard < 20000) begin
      // The overflow tail needs a nonzero cell so every open pushes.
      if (ending == END_OVERFLOW && prog_ctr[CTX_PLAN] == tail_at) begin
        step_once(8'($urandom_range(1, 255)));
      end else begin
        step_once(pick_input());
      end
      guard++;
    end
    repeat (2) step_once(8'($urandom));

    // Keep loading after the stop and confirm the stop holds.
    repeat (3) load_sym(sym_t'($urandom_range(0, 7)));
    repeat (2) step_once(8'($urandom));
  end

  // --------------------------------------------------------------------------
  // Clock, reset and known input levels from time zero
  // --------------------------------------------------------------------------
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_LOAD;
    in_ch.symbol     = SYM_RIGHT;
    in_ch.input_byte = 8'h00;
    out_ch.ready     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driver: one command per transaction, random idle cycles between them
  // --------------------------------------------------------------------------
  cmd_t        drv_cmd;
  int unsigned idle_left = 0;
  bit          in_burst  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      idle_left   = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // The slot is free after this edge: idle, present the next command,
      // or drop valid when nothing is left.
      if (idle_left != 0) begin
        in_ch.valid <= 1'b0;
        idle_left--;
      end else if (cmd_backlog.size() != 0) begin
        drv_cmd = cmd_backlog.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= drv_cmd.opcode;
        in_ch.symbol     <= drv_cmd.symbol;
        in_ch.input_byte <= drv_cmd.input_byte;
        // Switch between idling and back-to-back stretches now and then.
        if ($urandom_range(0, 23) == 0) in_burst = !in_burst;
        idle_left = in_burst ? 0 : $urandom_range(0, 3);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results first, then record the prediction for any input
  // transaction at the same edge, so queue order never depends on process
  // order.
  // --------------------------------------------------------------------------
  res_t        want;
  int unsigned stall_left = 0;
  int unsigned stall_now;
  bit          out_burst  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
    end else begin
      stall_now = stall_left;
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result: out_valid=%0b out_byte=%02h input_used=%0b status=%0d",
                     out_ch.out_valid, out_ch.out_byte, out_ch.input_used, out_ch.status);
          end
        end else begin
          want = pending_results.pop_front();
          if (out_ch.out_valid !== want.out_valid || out_ch.out_byte !== want.out_byte ||
              out_ch.input_used !== want.input_used || out_ch.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected out_valid=%0b out_byte=%02h input_used=%0b status=%0d",
                       want.out_valid, want.out_byte, want.input_used, want.status);
              $display("          actual   out_valid=%0b out_byte=%02h input_used=%0b status=%0d",
                       out_ch.out_valid, out_ch.out_byte, out_ch.input_used, out_ch.status);
            end
          end
        end
        if ($urandom_range(0, 23) == 0) out_burst = !out_burst;
        stall_now = out_burst ? 0 : $urandom_range(0, 3);
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(exec_bf_item(CTX_CHECK, in_ch.opcode,
                                               sym_t'(in_ch.symbol), in_ch.input_byte));
      end
      // Hold ready low for the drawn stall, whether or not a result waits.
      if (stall_now != 0) begin
        out_ch.ready <= 1'b0;
        stall_left   = stall_now - 1;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left   = 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // End of run
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_n);
    // Wait until every command has gone out and every result has come back.
    while (cmd_backlog.size() != 0 || in_ch.valid || pending_results.size() != 0) begin
      @(negedge clk);
    end
    // Give a stray late result time to show up.
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Cap the run well above the slowest correct one, tape sweep included.
  initial begin
    #(20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
